FILE: src/cfsd_pkg.sv
// ----------------------------------------------------------------------------
// cfsd_pkg
// Widths, register codes and inter-stage types of the spring-dashpot contact
// force pipeline.
// ----------------------------------------------------------------------------
package cfsd_pkg;

  localparam int unsigned PosW      = 32;
  localparam int unsigned DiffW     = PosW + 1;
  localparam int unsigned RadW      = 24;
  localparam int unsigned RsW       = RadW + 1;
  localparam int unsigned GainW     = 32;
  localparam int unsigned GainFrac  = 16;
  localparam int unsigned SqW       = 2 * RsW;
  localparam int unsigned SumSqW    = SqW + 1;
  localparam int unsigned RadicandW = SumSqW + 1;
  localparam int unsigned RootW     = RadicandW / 2;
  localparam int unsigned SqRemW    = RootW + 3;
  localparam int unsigned AW        = RsW + GainW;
  localparam int unsigned ALoW      = 32;
  localparam int unsigned AHiW      = AW - ALoW;
  localparam int unsigned ProdW     = AW + RsW;
  localparam int unsigned QuotW     = AW;
  localparam int unsigned DampPW    = DiffW + GainFrac;
  localparam int unsigned DampW     = DampPW + 2;
  localparam int unsigned ForceW    = 48;
  localparam int unsigned SumW      = DampW + 1;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 3;

  typedef enum logic {
    RegStiffness = 1'b0,
    RegDamping   = 1'b1
  } reg_idx_e;

  // Side data that rides along with the square root.
  typedef struct packed {
    logic                    dx_neg;
    logic                    dy_neg;
    logic                    early;
    logic [RsW-1:0]          adx;
    logic [RsW-1:0]          ady;
    logic [RsW-1:0]          rs;
    logic [DampW-1:0]        damp_x;
    logic [DampW-1:0]        damp_y;
  } sq_side_t;

  // Side data that rides along with the divider.
  typedef struct packed {
    logic                    dx_neg;
    logic                    dy_neg;
    logic                    contact;
    logic                    degen;
    logic [DampW-1:0]        damp_x;
    logic [DampW-1:0]        damp_y;
  } div_side_t;

endpackage

FILE: src/cfsd_sqrt.sv
// ----------------------------------------------------------------------------
// cfsd_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module cfsd_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [cfsd_pkg::RadicandW-1:0]     radicand_i,
  input  cfsd_pkg::sq_side_t                 side_i,
  output logic                               valid_o,
  output logic [cfsd_pkg::RootW-1:0]         root_o,
  output cfsd_pkg::sq_side_t                 side_o
);

  localparam int unsigned Steps = cfsd_pkg::RootW;

  logic                              valid_q [1:Steps];
  logic [cfsd_pkg::SqRemW-1:0]       rem_q   [1:Steps];
  logic [cfsd_pkg::RootW-1:0]        root_q  [1:Steps];
  logic [cfsd_pkg::RadicandW-1:0]    rad_q   [1:Steps];
  cfsd_pkg::sq_side_t                side_q  [1:Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic                            v_c;
    logic [cfsd_pkg::SqRemW-1:0]     rem_c;
    logic [cfsd_pkg::RootW-1:0]      root_c;
    logic [cfsd_pkg::RadicandW-1:0]  rad_c;
    cfsd_pkg::sq_side_t              side_c;
    logic [cfsd_pkg::SqRemW-1:0]     t_c;
    logic [cfsd_pkg::SqRemW-1:0]     trial_c;

    if (s == 0) begin : g_first
      assign v_c    = valid_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = radicand_i;
      assign side_c = side_i;
    end else begin : g_next
      assign v_c    = valid_q[s];
      assign rem_c  = rem_q[s];
      assign root_c = root_q[s];
      assign rad_c  = rad_q[s];
      assign side_c = side_q[s];
    end

    // Bring down the next two radicand bits and try 4*root + 1.
    assign t_c     = {rem_c[cfsd_pkg::SqRemW-3:0], rad_c[cfsd_pkg::RadicandW-1 -: 2]};
    assign trial_c = {{(cfsd_pkg::SqRemW-cfsd_pkg::RootW-2){1'b0}}, root_c, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t_c >= trial_c) begin
          rem_q[s+1]  <= t_c - trial_c;
          root_q[s+1] <= {root_c[cfsd_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_q[s+1]  <= t_c;
          root_q[s+1] <= {root_c[cfsd_pkg::RootW-2:0], 1'b0};
        end
        rad_q[s+1]  <= {rad_c[cfsd_pkg::RadicandW-3:0], 2'b00};
        side_q[s+1] <= side_c;
      end
    end
  end

  assign valid_o = valid_q[Steps];
  assign root_o  = root_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

FILE: src/cfsd_div.sv
// ----------------------------------------------------------------------------
// cfsd_div
// Pipelined restoring divider for both axes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cfsd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [cfsd_pkg::ProdW-1:0]      px_i,
  input  logic [cfsd_pkg::ProdW-1:0]      py_i,
  input  logic [cfsd_pkg::RootW-1:0]      dist_i,
  input  cfsd_pkg::div_side_t             side_i,
  output logic                            valid_o,
  output logic [cfsd_pkg::QuotW-1:0]      qx_o,
  output logic [cfsd_pkg::QuotW-1:0]      qy_o,
  output cfsd_pkg::div_side_t             side_o
);

  localparam int unsigned Steps = cfsd_pkg::QuotW;
  localparam int unsigned HiW   = cfsd_pkg::ProdW - cfsd_pkg::QuotW;
  localparam int unsigned RW    = cfsd_pkg::RootW;

  logic                            valid_q [1:Steps];
  logic [RW-1:0]                   rx_q    [1:Steps];
  logic [RW-1:0]                   ry_q    [1:Steps];
  logic [cfsd_pkg::QuotW-1:0]      wx_q    [1:Steps];
  logic [cfsd_pkg::QuotW-1:0]      wy_q    [1:Steps];
  logic [RW-1:0]                   dist_q  [1:Steps];
  cfsd_pkg::div_side_t             side_q  [1:Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic                          v_c;
    logic [RW-1:0]                 rx_c, ry_c, dist_c;
    logic [cfsd_pkg::QuotW-1:0]    wx_c, wy_c;
    cfsd_pkg::div_side_t           side_c;
    logic [RW:0]                   tx_c, ty_c, dd_c, subx_c, suby_c;
    logic                          gex_c, gey_c;

    if (s == 0) begin : g_first
      // The quotient fits in QuotW bits, so the top of the dividend is below dist.
      assign v_c    = valid_i;
      assign rx_c   = {{(RW-HiW){1'b0}}, px_i[cfsd_pkg::ProdW-1:cfsd_pkg::QuotW]};
      assign ry_c   = {{(RW-HiW){1'b0}}, py_i[cfsd_pkg::ProdW-1:cfsd_pkg::QuotW]};
      assign wx_c   = px_i[cfsd_pkg::QuotW-1:0];
      assign wy_c   = py_i[cfsd_pkg::QuotW-1:0];
      assign dist_c = dist_i;
      assign side_c = side_i;
    end else begin : g_next
      assign v_c    = valid_q[s];
      assign rx_c   = rx_q[s];
      assign ry_c   = ry_q[s];
      assign wx_c   = wx_q[s];
      assign wy_c   = wy_q[s];
      assign dist_c = dist_q[s];
      assign side_c = side_q[s];
    end

    assign dd_c   = {1'b0, dist_c};
    assign tx_c   = {rx_c, wx_c[cfsd_pkg::QuotW-1]};
    assign ty_c   = {ry_c, wy_c[cfsd_pkg::QuotW-1]};
    assign subx_c = tx_c - dd_c;
    assign suby_c = ty_c - dd_c;
    assign gex_c  = tx_c >= dd_c;
    assign gey_c  = ty_c >= dd_c;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= v_c;
      end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[s+1]   <= gex_c ? subx_c[RW-1:0] : tx_c[RW-1:0];
        ry_q[s+1]   <= gey_c ? suby_c[RW-1:0] : ty_c[RW-1:0];
        wx_q[s+1]   <= {wx_c[cfsd_pkg::QuotW-2:0], gex_c};
        wy_q[s+1]   <= {wy_c[cfsd_pkg::QuotW-2:0], gey_c};
        dist_q[s+1] <= dist_c;
        side_q[s+1] <= side_c;
      end
    end
  end

  assign valid_o = valid_q[Steps];
  assign qx_o    = wx_q[Steps];
  assign qy_o    = wy_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

FILE: src/cfsd_out.sv
// ----------------------------------------------------------------------------
// cfsd_out
// Final force sum with saturation, output register and skid register.
// ----------------------------------------------------------------------------
module cfsd_out (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [cfsd_pkg::QuotW-1:0]       qx_i,
  input  logic [cfsd_pkg::QuotW-1:0]       qy_i,
  input  cfsd_pkg::div_side_t              side_i,
  input  logic                             out_stall_i,
  output logic                             en_o,
  output logic                             out_valid_o,
  output logic [cfsd_pkg::ForceW-1:0]      force_x_o,
  output logic [cfsd_pkg::ForceW-1:0]      force_y_o,
  output logic                             in_contact_o,
  output logic                             degenerate_o
);

  localparam int unsigned MW = cfsd_pkg::QuotW - cfsd_pkg::GainFrac;

  typedef struct packed {
    logic [cfsd_pkg::ForceW-1:0] force_x;
    logic [cfsd_pkg::ForceW-1:0] force_y;
    logic                        contact;
    logic                        degen;
  } result_t;

  function automatic logic [cfsd_pkg::ForceW-1:0] axis_force(
    input logic [MW-1:0]               m,
    input logic                        d_neg,
    input logic [cfsd_pkg::DampW-1:0]  damp
  );
    logic [cfsd_pkg::SumW-1:0] ms;
    logic [cfsd_pkg::SumW-1:0] spring;
    logic [cfsd_pkg::SumW-1:0] sum;
    logic [cfsd_pkg::ForceW-1:0] res;
    ms     = {{(cfsd_pkg::SumW-MW){1'b0}}, m};
    // The spring pushes i away from j, against the sign of the offset.
    spring = d_neg ? ms : -ms;
    sum    = spring + {{(cfsd_pkg::SumW-cfsd_pkg::DampW){damp[cfsd_pkg::DampW-1]}}, damp};
    if (sum[cfsd_pkg::SumW-1:cfsd_pkg::ForceW-1] == '0 ||
        sum[cfsd_pkg::SumW-1:cfsd_pkg::ForceW-1] == '1) begin
      res = sum[cfsd_pkg::ForceW-1:0];
    end else if (sum[cfsd_pkg::SumW-1]) begin
      res = {1'b1, {(cfsd_pkg::ForceW-1){1'b0}}};
    end else begin
      res = {1'b0, {(cfsd_pkg::ForceW-1){1'b1}}};
    end
    return res;
  endfunction

  result_t res_c;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    take;

  always_comb begin
    res_c.contact = side_i.contact;
    res_c.degen   = side_i.degen;
    res_c.force_x = '0;
    res_c.force_y = '0;
    if (side_i.contact) begin
      res_c.force_x = axis_force(qx_i[cfsd_pkg::QuotW-1:cfsd_pkg::GainFrac], side_i.dx_neg,
                                 side_i.damp_x);
      res_c.force_y = axis_force(qy_i[cfsd_pkg::QuotW-1:cfsd_pkg::GainFrac], side_i.dy_neg,
                                 side_i.damp_y);
    end
  end

  assign take = out_valid_q & ~out_stall_i;
  assign en_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q) begin
      if (!out_valid_q || take) begin
        out_valid_q <= valid_i;
      end else begin
        skid_valid_q <= valid_i;
      end
    end else if (take) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      if (!out_valid_q || take) begin
        out_q <= res_c;
      end else begin
        skid_q <= res_c;
      end
    end else if (take) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign force_x_o    = out_q.force_x;
  assign force_y_o    = out_q.force_y;
  assign in_contact_o = out_q.contact;
  assign degenerate_o = out_q.degen;

endmodule

FILE: src/contact_force_spring_dashpot.sv
// ----------------------------------------------------------------------------
// contact_force_spring_dashpot
// Linear spring-dashpot contact force between two discs in 2D, one pair per
// cycle through a deep pipeline.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o  positions, velocities, radii
// out       source     out_valid_o / out_stall_i force_x/y, in_contact, degenerate
// cfg       APB slave  psel/penable/pwrite      spring_stiffness @0, damping_gain @4
//
// One item enters per cycle while in_stall_o is low; the path to the output register
// runs through 26 square root stages and 57 divider stages plus 8 other stages.
// Reset clears all valid bits and both gain registers to zero.
// A stalled output fills the skid register, and in_stall_o then freezes the
// whole pipeline until the skid item moves to the output register.
// ----------------------------------------------------------------------------
module contact_force_spring_dashpot (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cfsd_pkg::AddrW-1:0]        paddr,
  input  logic [cfsd_pkg::DataW-1:0]        pwdata,
  output logic [cfsd_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cfsd_pkg::PosW-1:0]         pos_i_x_i,
  input  logic [cfsd_pkg::PosW-1:0]         pos_i_y_i,
  input  logic [cfsd_pkg::PosW-1:0]         pos_j_x_i,
  input  logic [cfsd_pkg::PosW-1:0]         pos_j_y_i,
  input  logic [cfsd_pkg::PosW-1:0]         vel_i_x_i,
  input  logic [cfsd_pkg::PosW-1:0]         vel_i_y_i,
  input  logic [cfsd_pkg::PosW-1:0]         vel_j_x_i,
  input  logic [cfsd_pkg::PosW-1:0]         vel_j_y_i,
  input  logic [cfsd_pkg::RadW-1:0]         radius_i_i,
  input  logic [cfsd_pkg::RadW-1:0]         radius_j_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cfsd_pkg::ForceW-1:0]       force_x_o,
  output logic [cfsd_pkg::ForceW-1:0]       force_y_o,
  output logic                              in_contact_o,
  output logic                              degenerate_o
);

  localparam int unsigned DW  = cfsd_pkg::DiffW;
  localparam int unsigned RsW = cfsd_pkg::RsW;
  localparam int unsigned GF  = cfsd_pkg::GainFrac;

  // Configuration registers.
  logic [cfsd_pkg::GainW-1:0] stiff_q, damp_q;
  cfsd_pkg::reg_idx_e         reg_idx;

  assign reg_idx = cfsd_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= '0;
      damp_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        cfsd_pkg::RegStiffness: stiff_q <= pwdata;
        cfsd_pkg::RegDamping:   damp_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cfsd_pkg::RegStiffness: prdata = stiff_q;
      cfsd_pkg::RegDamping:   prdata = damp_q;
      default:                prdata = '0;
    endcase
  end

  logic en;
  assign in_stall_o = ~en;

  // Stage 1: offsets, velocity differences and radius sum.
  logic           s1_v_q;
  logic [DW-1:0]  s1_dx_q, s1_dy_q, s1_dvx_q, s1_dvy_q;
  logic [RsW-1:0] s1_rs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q  <= {pos_j_x_i[cfsd_pkg::PosW-1], pos_j_x_i} - {pos_i_x_i[cfsd_pkg::PosW-1], pos_i_x_i};
      s1_dy_q  <= {pos_j_y_i[cfsd_pkg::PosW-1], pos_j_y_i} - {pos_i_y_i[cfsd_pkg::PosW-1], pos_i_y_i};
      s1_dvx_q <= {vel_j_x_i[cfsd_pkg::PosW-1], vel_j_x_i} - {vel_i_x_i[cfsd_pkg::PosW-1], vel_i_x_i};
      s1_dvy_q <= {vel_j_y_i[cfsd_pkg::PosW-1], vel_j_y_i} - {vel_i_y_i[cfsd_pkg::PosW-1], vel_i_y_i};
      s1_rs_q  <= {1'b0, radius_i_i} + {1'b0, radius_j_i};
    end
  end

  // Stage 2: magnitudes, early reject, squares and damping partial products.
  logic [DW-1:0]  adx_c, ady_c, advx_c, advy_c;
  logic           early_c;

  assign adx_c   = s1_dx_q[DW-1]  ? -s1_dx_q  : s1_dx_q;
  assign ady_c   = s1_dy_q[DW-1]  ? -s1_dy_q  : s1_dy_q;
  assign advx_c  = s1_dvx_q[DW-1] ? -s1_dvx_q : s1_dvx_q;
  assign advy_c  = s1_dvy_q[DW-1] ? -s1_dvy_q : s1_dvy_q;
  // A component at least as long as the radius sum rules out any overlap.
  assign early_c = (adx_c >= {{(DW-RsW){1'b0}}, s1_rs_q}) ||
                   (ady_c >= {{(DW-RsW){1'b0}}, s1_rs_q});

  logic                           s2_v_q, s2_early_q;
  logic                           s2_dx_neg_q, s2_dy_neg_q, s2_dvx_neg_q, s2_dvy_neg_q;
  logic [RsW-1:0]                 s2_adx_q, s2_ady_q, s2_rs_q;
  logic [cfsd_pkg::SqW-1:0]       s2_sqx_q, s2_sqy_q;
  logic [cfsd_pkg::DampPW-1:0]    s2_phx_q, s2_plx_q, s2_phy_q, s2_ply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_early_q   <= early_c;
      s2_dx_neg_q  <= s1_dx_q[DW-1];
      s2_dy_neg_q  <= s1_dy_q[DW-1];
      s2_dvx_neg_q <= s1_dvx_q[DW-1];
      s2_dvy_neg_q <= s1_dvy_q[DW-1];
      s2_adx_q     <= adx_c[RsW-1:0];
      s2_ady_q     <= ady_c[RsW-1:0];
      s2_rs_q      <= s1_rs_q;
      s2_sqx_q     <= adx_c[RsW-1:0] * adx_c[RsW-1:0];
      s2_sqy_q     <= ady_c[RsW-1:0] * ady_c[RsW-1:0];
      s2_phx_q     <= advx_c * damp_q[cfsd_pkg::GainW-1:GF];
      s2_plx_q     <= advx_c * damp_q[GF-1:0];
      s2_phy_q     <= advy_c * damp_q[cfsd_pkg::GainW-1:GF];
      s2_ply_q     <= advy_c * damp_q[GF-1:0];
    end
  end

  // Stage 3: sum of squares and signed damping terms.
  logic [cfsd_pkg::DampW-2:0] dmx_c, dmy_c;

  assign dmx_c = {1'b0, s2_phx_q} + {{(GF+1){1'b0}}, s2_plx_q[cfsd_pkg::DampPW-1:GF]};
  assign dmy_c = {1'b0, s2_phy_q} + {{(GF+1){1'b0}}, s2_ply_q[cfsd_pkg::DampPW-1:GF]};

  logic                             s3_v_q;
  logic [cfsd_pkg::RadicandW-1:0]   s3_rad_q;
  cfsd_pkg::sq_side_t               s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rad_q         <= {2'b00, s2_sqx_q} + {2'b00, s2_sqy_q};
      s3_side_q.dx_neg <= s2_dx_neg_q;
      s3_side_q.dy_neg <= s2_dy_neg_q;
      s3_side_q.early  <= s2_early_q;
      s3_side_q.adx    <= s2_adx_q;
      s3_side_q.ady    <= s2_ady_q;
      s3_side_q.rs     <= s2_rs_q;
      s3_side_q.damp_x <= s2_dvx_neg_q ? -{1'b0, dmx_c} : {1'b0, dmx_c};
      s3_side_q.damp_y <= s2_dvy_neg_q ? -{1'b0, dmy_c} : {1'b0, dmy_c};
    end
  end

  logic                           sq_v;
  logic [cfsd_pkg::RootW-1:0]     sq_root;
  cfsd_pkg::sq_side_t             sq_side;

  cfsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s3_v_q),
    .radicand_i (s3_rad_q),
    .side_i     (s3_side_q),
    .valid_o    (sq_v),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  // Stage 4: overlap test and overlap depth.
  logic ov_c;
  assign ov_c = !sq_side.early && ({1'b0, sq_side.rs} > sq_root);

  logic                         s4_v_q;
  logic [RsW-1:0]               s4_eps_q, s4_adx_q, s4_ady_q;
  logic [cfsd_pkg::RootW-1:0]   s4_dist_q;
  cfsd_pkg::div_side_t          s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_eps_q          <= sq_side.rs - sq_root[RsW-1:0];
      s4_adx_q          <= sq_side.adx;
      s4_ady_q          <= sq_side.ady;
      s4_dist_q         <= sq_root;
      s4_side_q.dx_neg  <= sq_side.dx_neg;
      s4_side_q.dy_neg  <= sq_side.dy_neg;
      s4_side_q.contact <= ov_c && (sq_root != '0);
      s4_side_q.degen   <= ov_c && (sq_root == '0);
      s4_side_q.damp_x  <= sq_side.damp_x;
      s4_side_q.damp_y  <= sq_side.damp_y;
    end
  end

  // Stage 5: eps * k.
  logic                         s5_v_q;
  logic [cfsd_pkg::AW-1:0]      s5_a_q;
  logic [RsW-1:0]               s5_adx_q, s5_ady_q;
  logic [cfsd_pkg::RootW-1:0]   s5_dist_q;
  cfsd_pkg::div_side_t          s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_a_q    <= s4_eps_q * stiff_q;
      s5_adx_q  <= s4_adx_q;
      s5_ady_q  <= s4_ady_q;
      s5_dist_q <= s4_dist_q;
      s5_side_q <= s4_side_q;
    end
  end

  // Stage 6: partial products of a * |d| on both axes.
  logic                                  s6_v_q;
  logic [cfsd_pkg::ALoW+RsW-1:0]         s6_lox_q, s6_loy_q;
  logic [cfsd_pkg::AHiW+RsW-1:0]         s6_hix_q, s6_hiy_q;
  logic [cfsd_pkg::RootW-1:0]            s6_dist_q;
  cfsd_pkg::div_side_t                   s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_lox_q  <= s5_a_q[cfsd_pkg::ALoW-1:0] * s5_adx_q;
      s6_loy_q  <= s5_a_q[cfsd_pkg::ALoW-1:0] * s5_ady_q;
      s6_hix_q  <= s5_a_q[cfsd_pkg::AW-1:cfsd_pkg::ALoW] * s5_adx_q;
      s6_hiy_q  <= s5_a_q[cfsd_pkg::AW-1:cfsd_pkg::ALoW] * s5_ady_q;
      s6_dist_q <= s5_dist_q;
      s6_side_q <= s5_side_q;
    end
  end

  // Stage 7: full dividends.
  localparam int unsigned LoPad = cfsd_pkg::ProdW - cfsd_pkg::ALoW - RsW;

  logic                         s7_v_q;
  logic [cfsd_pkg::ProdW-1:0]   s7_px_q, s7_py_q;
  logic [cfsd_pkg::RootW-1:0]   s7_dist_q;
  cfsd_pkg::div_side_t          s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_px_q   <= {s6_hix_q, {cfsd_pkg::ALoW{1'b0}}} + {{LoPad{1'b0}}, s6_lox_q};
      s7_py_q   <= {s6_hiy_q, {cfsd_pkg::ALoW{1'b0}}} + {{LoPad{1'b0}}, s6_loy_q};
      s7_dist_q <= s6_dist_q;
      s7_side_q <= s6_side_q;
    end
  end

  logic                         dv_v;
  logic [cfsd_pkg::QuotW-1:0]   dv_qx, dv_qy;
  cfsd_pkg::div_side_t          dv_side;

  cfsd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .px_i    (s7_px_q),
    .py_i    (s7_py_q),
    .dist_i  (s7_dist_q),
    .side_i  (s7_side_q),
    .valid_o (dv_v),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy),
    .side_o  (dv_side)
  );

  cfsd_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (dv_v),
    .qx_i         (dv_qx),
    .qy_i         (dv_qy),
    .side_i       (dv_side),
    .out_stall_i  (out_stall_i),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .force_x_o    (force_x_o),
    .force_y_o    (force_y_o),
    .in_contact_o (in_contact_o),
    .degenerate_o (degenerate_o)
  );

endmodule

FILE: src/cfsd_checker.sv
// ----------------------------------------------------------------------------
// cfsd_checker
// Port-level checks of the contact force block, bound to the top level.
// ----------------------------------------------------------------------------
module cfsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [cfsd_pkg::ForceW-1:0]  force_x_o,
  input logic [cfsd_pkg::ForceW-1:0]  force_y_o,
  input logic                         in_contact_o,
  input logic                         degenerate_o
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(in_contact_o && degenerate_o))
    else $error("contact and degenerate both set");

  // Without contact no force is applied.
  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_contact_o |-> force_x_o == '0 && force_y_o == '0)
    else $error("force without contact");

  // The input stalls only after a result was held back at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

bind contact_force_spring_dashpot cfsd_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .force_x_o    (force_x_o),
  .force_y_o    (force_y_o),
  .in_contact_o (in_contact_o),
  .degenerate_o (degenerate_o)
);
